[rtl/adv_data_uuid128_filter_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the advertising-data UUID filter
// ----------------------------------------------------------------------------
`ifndef ADV_DATA_UUID128_FILTER_TOP_MACROS_SVH
`define ADV_DATA_UUID128_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aduf_pkg.sv]
// ----------------------------------------------------------------------------
// aduf_pkg
// Shared types and constants of the advertising-data UUID filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aduf_pkg;

    typedef enum logic [2:0] {
        OC_NONE      = 3'd0,
        OC_MATCH     = 3'd1,
        OC_MALFORMED = 3'd2,
        OC_ZERO      = 3'd3,
        OC_PDU       = 3'd4
    } outcome_t;

    typedef enum logic [3:0] {
        PH_LENGTH  = 4'b0001,
        PH_TYPE    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } phase_t;

    localparam logic [1:0] REG_UUID_LOW        = 2'd0;
    localparam logic [1:0] REG_UUID_HIGH       = 2'd1;
    localparam logic [1:0] REG_WANTED_AD_TYPE  = 2'd2;
    localparam logic [1:0] REG_WANTED_PDU_TYPE = 2'd3;

    localparam logic [7:0] RESET_AD_TYPE  = 8'd7;
    localparam logic [3:0] RESET_PDU_TYPE = 4'd0;

    localparam int         UUID_BYTES  = 16;
    localparam int         QUEUE_DEPTH = 4;
    localparam logic [6:0] COUNT_MAX   = 7'd127;

    // one classified byte on its way from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] length;
        logic       pdu_bad;
        logic       first;
        logic       last;
    } queue_item_t;

    // configuration the parser needs
    typedef struct packed {
        logic [127:0] uuid;
        logic [7:0]   wanted_ad_type;
    } back_cfg_t;

endpackage

[rtl/aduf_front.sv]
// ----------------------------------------------------------------------------
// aduf_front
// Classifies an incoming byte: clamps the report length, flags a PDU type
// that is not parsed, and packs the item for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aduf_front
    import aduf_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 31
)
(
    input  logic [7:0]  data_byte,
    input  logic [3:0]  pdu_type,
    input  logic [7:0]  report_length,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [3:0]  wanted_pdu_type,
    output queue_item_t item
);

    localparam logic [7:0] MaxLen = 8'(MAX_REPORT_BYTES);

    always_comb
    begin
        item.data_byte = data_byte;
        item.length    = (report_length > MaxLen) ? MaxLen : report_length;
        item.pdu_bad   = (pdu_type != wanted_pdu_type);
        item.first     = first_byte;
        item.last      = last_byte;
    end

endmodule

[rtl/aduf_queue.sv]
// ----------------------------------------------------------------------------
// aduf_queue
// Short first-in first-out queue between the front and the parser.
// DEPTH must be a power of two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aduf_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PtrW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PtrW:0]    wr_ptr_reg;
    logic [PtrW:0]    rd_ptr_reg;

    assign not_empty = (wr_ptr_reg != rd_ptr_reg);
    assign full      = (wr_ptr_reg[PtrW] != rd_ptr_reg[PtrW])
                    && (wr_ptr_reg[PtrW-1:0] == rd_ptr_reg[PtrW-1:0]);
    assign pop_data  = slot_reg[rd_ptr_reg[PtrW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + (PtrW + 1)'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + (PtrW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg[PtrW-1:0]] <= push_data;
        end
    end

endmodule

[rtl/aduf_back.sv]
// ----------------------------------------------------------------------------
// aduf_back
// AD structure parser: walks length-type-value structures one byte a cycle
// if no last byte waits; checks 16-byte UUID chunks and holds the outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aduf_back
    import aduf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  back_cfg_t   cfg,
    input  logic        item_valid,
    input  queue_item_t item,
    output logic        item_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output outcome_t    outcome,
    output logic [6:0]  structures_seen
);

    phase_t     phase_reg, phase_next;
    logic [7:0] consumed_reg, consumed_next;
    logic [7:0] left_reg, left_next;
    logic [3:0] pos_reg, pos_next;
    logic       all_eq_reg, all_eq_next;
    logic       type_wanted_reg, type_wanted_next;
    outcome_t   oc_reg, oc_next;
    logic       fixed_reg, fixed_next;
    logic [6:0] count_reg, count_next;
    logic [7:0] rlen_reg, rlen_next;

    logic       out_valid_reg;
    outcome_t   out_oc_reg;
    logic [6:0] out_count_reg;

    // state after the first-byte clear
    phase_t     cur_phase;
    logic [7:0] cur_consumed;
    logic [7:0] cur_left;
    logic [3:0] cur_pos;
    logic       cur_all_eq;
    logic       cur_type_wanted;
    outcome_t   cur_oc;
    logic       cur_fixed;
    logic [6:0] cur_count;
    logic [7:0] cur_rlen;

    logic [7:0] room;
    logic [7:0] uuid_byte;
    logic       byte_eq;
    logic [7:0] left_dec;

    // hold a last byte while the previous outcome is still unread
    assign item_pop        = item_valid && (!item.last || !out_valid_reg || out_ready);
    assign out_valid       = out_valid_reg;
    assign outcome         = out_oc_reg;
    assign structures_seen = out_count_reg;

    always_comb
    begin
        cur_phase       = phase_reg;
        cur_consumed    = consumed_reg;
        cur_left        = left_reg;
        cur_pos         = pos_reg;
        cur_all_eq      = all_eq_reg;
        cur_type_wanted = type_wanted_reg;
        cur_oc          = oc_reg;
        cur_fixed       = fixed_reg;
        cur_count       = count_reg;
        cur_rlen        = rlen_reg;
        if (item.first)
        begin
            cur_phase       = PH_LENGTH;
            cur_consumed    = '0;
            cur_left        = '0;
            cur_pos         = '0;
            cur_all_eq      = 1'b1;
            cur_type_wanted = 1'b0;
            cur_oc          = OC_NONE;
            cur_fixed       = 1'b0;
            cur_count       = '0;
            cur_rlen        = item.length;
            if (item.pdu_bad)
            begin
                cur_oc    = OC_PDU;
                cur_fixed = 1'b1;
            end
        end

        room      = cur_rlen - cur_consumed - 8'd1;
        uuid_byte = cfg.uuid[{cur_pos, 3'b000} +: 8];
        byte_eq   = cur_all_eq && (item.data_byte == uuid_byte);
        left_dec  = (cur_left != 8'd0) ? (cur_left - 8'd1) : cur_left;

        phase_next       = cur_phase;
        consumed_next    = cur_consumed;
        left_next        = cur_left;
        pos_next         = cur_pos;
        all_eq_next      = cur_all_eq;
        type_wanted_next = cur_type_wanted;
        oc_next          = cur_oc;
        fixed_next       = cur_fixed;
        count_next       = cur_count;
        rlen_next        = cur_rlen;

        if (!cur_fixed && (cur_consumed < cur_rlen))
        begin
            case (cur_phase)
                PH_LENGTH:
                begin
                    if ((cur_consumed + 8'd1) >= cur_rlen)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (item.data_byte == 8'd0)
                    begin
                        oc_next    = OC_ZERO;
                        fixed_next = 1'b1;
                    end
                    else if (item.data_byte > room)
                    begin
                        oc_next    = OC_MALFORMED;
                        fixed_next = 1'b1;
                    end
                    else
                    begin
                        if (cur_count != COUNT_MAX)
                        begin
                            count_next = cur_count + 7'd1;
                        end
                        left_next  = item.data_byte - 8'd1;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_wanted_next = (item.data_byte == cfg.wanted_ad_type);
                    pos_next         = '0;
                    all_eq_next      = 1'b1;
                    phase_next       = (cur_left != 8'd0) ? PH_PAYLOAD : PH_LENGTH;
                end
                PH_PAYLOAD:
                begin
                    if (cur_type_wanted)
                    begin
                        if (cur_pos == 4'(UUID_BYTES - 1))
                        begin
                            if (byte_eq)
                            begin
                                oc_next    = OC_MATCH;
                                fixed_next = 1'b1;
                            end
                            pos_next    = '0;
                            all_eq_next = 1'b1;
                        end
                        else
                        begin
                            pos_next    = cur_pos + 4'd1;
                            all_eq_next = byte_eq;
                        end
                    end
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                    begin
                        phase_next = PH_LENGTH;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cur_consumed != 8'hFF)
        begin
            consumed_next = cur_consumed + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LENGTH;
            consumed_reg    <= '0;
            left_reg        <= '0;
            pos_reg         <= '0;
            all_eq_reg      <= 1'b1;
            type_wanted_reg <= 1'b0;
            oc_reg          <= OC_NONE;
            fixed_reg       <= 1'b0;
            count_reg       <= '0;
            rlen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (item_pop && item.last)
            begin
                // report closed: drop back to the idle state
                phase_reg       <= PH_LENGTH;
                consumed_reg    <= '0;
                left_reg        <= '0;
                pos_reg         <= '0;
                all_eq_reg      <= 1'b1;
                type_wanted_reg <= 1'b0;
                oc_reg          <= OC_NONE;
                fixed_reg       <= 1'b0;
                count_reg       <= '0;
                rlen_reg        <= '0;
            end
            else if (item_pop)
            begin
                phase_reg       <= phase_next;
                consumed_reg    <= consumed_next;
                left_reg        <= left_next;
                pos_reg         <= pos_next;
                all_eq_reg      <= all_eq_next;
                type_wanted_reg <= type_wanted_next;
                oc_reg          <= oc_next;
                fixed_reg       <= fixed_next;
                count_reg       <= count_next;
                rlen_reg        <= rlen_next;
            end

            if (item_pop && item.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop && item.last)
        begin
            out_oc_reg    <= oc_next;
            out_count_reg <= count_next;
        end
    end

endmodule

[rtl/adv_data_uuid128_filter_top.sv]
// Timing: an accepted byte passes through the queue to the parser; a result
// is registered on out_valid when the parser takes its last byte.
// Throughput: one byte per cycle while the queue has room; a last
// byte waits in the queue only while the previous result is still unread.
// Reset: asynchronous, active low; clears the queue, the parser state and the
// configuration registers to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
// adv_data_uuid128_filter_top
// Advertising-data 128-bit UUID filter with APB configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adv_data_uuid128_filter_top
    import aduf_pkg::*;
#(
    parameter int MAX_REPORT_BYTES = 31
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  pdu_type,
    input  logic [7:0]  report_length,
    input  logic        first_byte,
    input  logic        last_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  outcome,
    output logic [6:0]  structures_seen
);

    logic [63:0] uuid_low_reg;
    logic [63:0] uuid_high_reg;
    logic [7:0]  wanted_ad_type_reg;
    logic [3:0]  wanted_pdu_type_reg;

    logic        wr_en;
    logic [1:0]  reg_index;

    queue_item_t front_item;
    queue_item_t back_item;
    logic        q_full;
    logic        q_not_empty;
    logic        q_pop;
    back_cfg_t   back_cfg;
    outcome_t    back_outcome;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            uuid_low_reg        <= '0;
            uuid_high_reg       <= '0;
            wanted_ad_type_reg  <= RESET_AD_TYPE;
            wanted_pdu_type_reg <= RESET_PDU_TYPE;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_UUID_LOW:        uuid_low_reg        <= pwdata;
                REG_UUID_HIGH:       uuid_high_reg       <= pwdata;
                REG_WANTED_AD_TYPE:  wanted_ad_type_reg  <= pwdata[7:0];
                REG_WANTED_PDU_TYPE: wanted_pdu_type_reg <= pwdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_UUID_LOW:        prdata = uuid_low_reg;
            REG_UUID_HIGH:       prdata = uuid_high_reg;
            REG_WANTED_AD_TYPE:  prdata = {56'd0, wanted_ad_type_reg};
            REG_WANTED_PDU_TYPE: prdata = {60'd0, wanted_pdu_type_reg};
            default:             prdata = '0;
        endcase
    end

    assign back_cfg.uuid           = {uuid_high_reg, uuid_low_reg};
    assign back_cfg.wanted_ad_type = wanted_ad_type_reg;

    assign in_ready = !q_full;

    aduf_front #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_front (
        .data_byte       (data_byte),
        .pdu_type        (pdu_type),
        .report_length   (report_length),
        .first_byte      (first_byte),
        .last_byte       (last_byte),
        .wanted_pdu_type (wanted_pdu_type_reg),
        .item            (front_item)
    );

    aduf_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(queue_item_t))
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (back_item)
    );

    aduf_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (back_cfg),
        .item_valid      (q_not_empty),
        .item            (back_item),
        .item_pop        (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .outcome         (back_outcome),
        .structures_seen (structures_seen)
    );

    assign outcome = back_outcome;

endmodule

[rtl/aduf_checker.sv]
// ----------------------------------------------------------------------------
// aduf_checker
// Port-level checks of the UUID filter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adv_data_uuid128_filter_top_macros.svh"

module aduf_checker
    import aduf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] outcome,
    input logic [6:0] structures_seen
);

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(outcome) && $stable(structures_seen), "stalled result changed")

    `ASSERT_IMPL(a_pready_high, clk, rst_n, 1'b1, pready, "pready dropped")

    // a wrong PDU type stops the walk before any length byte
    `ASSERT_IMPL(a_pdu_no_count, clk, rst_n, out_valid && (outcome == OC_PDU), structures_seen == 7'd0, "wrong PDU type with structures counted")

    // a match needs at least one accepted structure
    `ASSERT_IMPL(a_match_count, clk, rst_n, out_valid && (outcome == OC_MATCH), structures_seen != 7'd0, "match without a structure")

    `ASSERT_IMPL(a_outcome_code, clk, rst_n, out_valid, (outcome == OC_NONE) || (outcome == OC_MATCH) || (outcome == OC_MALFORMED) || (outcome == OC_ZERO) || (outcome == OC_PDU), "undefined outcome code")

endmodule

bind adv_data_uuid128_filter_top aduf_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pready          (pready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .outcome         (outcome),
    .structures_seen (structures_seen)
);
